[rtl/core/json_stream_tokenizer_assert.svh]
// -----------------------------------------------------------------------------
// json_stream_tokenizer_assert.svh
// assertion macros used by the tokenizer rtl
// -----------------------------------------------------------------------------
`ifndef JSON_STREAM_TOKENIZER_ASSERT_SVH
`define JSON_STREAM_TOKENIZER_ASSERT_SVH

// implication checked on the same edge
`define JST_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// implication checked on the following edge
`define JST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

[rtl/core/jst_pkg.sv]
// -----------------------------------------------------------------------------
// jst_pkg
// types and character codes for the json stream tokenizer
// -----------------------------------------------------------------------------
package jst_pkg;

   localparam int unsigned DEPTH_BITS_DEFAULT = 8;

   localparam int unsigned KEY_LEN_W   = 7;
   localparam int unsigned VALUE_LEN_W = 10;
   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned REPORT_W    = 8;

   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
   localparam logic [CHAR_W-1:0] CH_BSL     = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;
   localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;

   // csr register indexes
   localparam logic REG_KEY_LIMIT   = 1'b0;
   localparam logic REG_VALUE_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      EV_KEY_CHAR   = 2'd0,
      EV_VALUE_CHAR = 2'd1,
      EV_COMMIT     = 2'd2
   } event_kind_type;

   // parse state apart from the nesting depths
   typedef struct packed {
      logic                   in_quotes;
      logic                   seeking_key;
      logic [KEY_LEN_W-1:0]   key_count;
      logic [VALUE_LEN_W-1:0] value_count;
      logic [CHAR_W-1:0]      previous_byte;
   } parse_state_type;

   typedef struct packed {
      event_kind_type         event_kind;
      logic [CHAR_W-1:0]      out_char;
      logic [REPORT_W-1:0]    object_depth;
      logic [REPORT_W-1:0]    array_depth;
      logic [KEY_LEN_W-1:0]   key_length;
      logic [VALUE_LEN_W-1:0] value_length;
   } token_type;

   typedef struct packed {
      logic [KEY_LEN_W-1:0]   key_limit;
      logic [VALUE_LEN_W-1:0] value_limit;
   } limits_type;

endpackage

[rtl/core/jst_step.sv]
// -----------------------------------------------------------------------------
// jst_step
// next parse state and token for one byte, pure combinational
// -----------------------------------------------------------------------------
module jst_step #(
   parameter int unsigned DEPTH_BITS = jst_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic [jst_pkg::CHAR_W-1:0] text_byte,
   input  logic                       restart,
   input  jst_pkg::parse_state_type   state,
   input  logic [DEPTH_BITS-1:0]      brace_count,
   input  logic [DEPTH_BITS-1:0]      bracket_count,
   input  jst_pkg::limits_type        limits,
   output jst_pkg::parse_state_type   state_next,
   output logic [DEPTH_BITS-1:0]      brace_next,
   output logic [DEPTH_BITS-1:0]      bracket_next,
   output logic                       token_valid,
   output jst_pkg::token_type         token
);
   import jst_pkg::*;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

   parse_state_type         base;
   logic [DEPTH_BITS-1:0]   brace_base;
   logic [DEPTH_BITS-1:0]   bracket_base;
   logic                    quote_toggle;
   logic                    skip;

   // restart clears everything but the previous byte
   always_comb begin
      base = state;
      brace_base = brace_count;
      bracket_base = bracket_count;
      if (restart) begin
         base.in_quotes   = 1'b0;
         base.seeking_key = 1'b0;
         base.key_count   = '0;
         base.value_count = '0;
         brace_base       = '0;
         bracket_base     = '0;
      end
   end

   always_comb begin
      state_next   = base;
      brace_next   = brace_base;
      bracket_next = bracket_base;
      token_valid  = 1'b0;
      token        = '0;
      quote_toggle = (text_byte == CH_QUOTE) && (state.previous_byte != CH_BSL);
      skip         = quote_toggle ||
                     ((text_byte == CH_BSL) && (state.previous_byte != CH_BSL));

      if (text_byte != CH_NUL) begin
         state_next.in_quotes = base.in_quotes ^ quote_toggle;

         if (!state_next.in_quotes) begin
            unique case (text_byte)
               CH_LBRACE: begin
                  if (brace_base != DEPTH_MAX) brace_next = brace_base + 1'b1;
                  state_next.seeking_key = 1'b1;
                  state_next.key_count   = '0;
                  skip = 1'b1;
               end
               CH_LBRACK: begin
                  if (bracket_base != DEPTH_MAX) bracket_next = bracket_base + 1'b1;
                  state_next.seeking_key = 1'b1;
                  state_next.key_count   = '0;
                  skip = 1'b1;
               end
               CH_RBRACK: begin
                  if (bracket_base != '0) bracket_next = bracket_base - 1'b1;
                  skip = 1'b1;
               end
               CH_RBRACE, CH_COMMA: begin
                  // commit reports the depth before a closing decrement
                  token_valid        = 1'b1;
                  token.event_kind   = EV_COMMIT;
                  token.object_depth = REPORT_W'(brace_base);
                  token.array_depth  = REPORT_W'(bracket_base);
                  token.key_length   = base.key_count;
                  token.value_length = base.value_count;
                  state_next.seeking_key = 1'b1;
                  state_next.key_count   = '0;
                  state_next.value_count = '0;
                  skip = 1'b1;
                  if (text_byte == CH_RBRACE && brace_base != '0) begin
                     brace_next = brace_base - 1'b1;
                  end
               end
               CH_TAB, CH_LF, CH_CR: begin
                  skip = 1'b1;
               end
               CH_COLON: begin
                  state_next.seeking_key = 1'b0;
                  state_next.value_count = '0;
                  skip = 1'b1;
               end
               default: begin
               end
            endcase
         end

         if (!skip) begin
            if (state_next.seeking_key) begin
               if (state_next.in_quotes && state_next.key_count < limits.key_limit) begin
                  state_next.key_count = state_next.key_count + 1'b1;
                  token_valid      = 1'b1;
                  token.event_kind = EV_KEY_CHAR;
                  token.out_char   = text_byte;
               end
            end else if (state_next.value_count < limits.value_limit &&
                         (text_byte != CH_SPACE || state_next.in_quotes)) begin
               state_next.value_count = state_next.value_count + 1'b1;
               token_valid      = 1'b1;
               token.event_kind = EV_VALUE_CHAR;
               token.out_char   = text_byte;
            end
         end

         state_next.previous_byte = text_byte;
      end
   end

endmodule

[rtl/core/json_stream_tokenizer.sv]
// token path: an accepted byte is held in the input register, its token in the result register
// one byte per cycle while rsp is not back-pressured; the parse state loop closes through combinational jst_step
// bytes that yield no token are consumed without an rsp transaction
// reset: synchronous, active high; clears parse state (but sets seeking_key), depths and valids,
// and loads key_limit 127 and value_limit 1023
// -----------------------------------------------------------------------------
// json_stream_tokenizer
// streaming json tokenizer emitting key/value characters and commit records
// -----------------------------------------------------------------------------
module json_stream_tokenizer #(
   parameter int unsigned DEPTH_BITS = jst_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic [0:0]  req_tuser,   // [0] restart
   // token stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] out_char, [15:8] object_depth,
                                    // [23:16] array_depth, [30:24] key_length,
                                    // [40:31] value_length, [47:41] zero
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [9:0]  csr_data
);
   import jst_pkg::*;

   logic                  stage_valid_ff, stage_valid_in;
   logic [CHAR_W-1:0]     stage_byte_ff;
   logic                  stage_restart_ff;
   parse_state_type       state_ff, state_in;
   logic [DEPTH_BITS-1:0] brace_ff, brace_in;
   logic [DEPTH_BITS-1:0] bracket_ff, bracket_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   token_type             rsp_ff;
   limits_type            limits_ff, limits_in;

   parse_state_type       step_state;
   logic [DEPTH_BITS-1:0] step_brace;
   logic [DEPTH_BITS-1:0] step_bracket;
   logic                  step_valid;
   token_type             step_token;

   logic                  req_accept;
   logic                  out_open;
   logic                  advance;

   logic                  rsp_is_commit;
   logic                  rsp_report_zero;
   logic                  stage_stalled;

   jst_step #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_step (
      .text_byte     (stage_byte_ff),
      .restart       (stage_restart_ff),
      .state         (state_ff),
      .brace_count   (brace_ff),
      .bracket_count (bracket_ff),
      .limits        (limits_ff),
      .state_next    (step_state),
      .brace_next    (step_brace),
      .bracket_next  (step_bracket),
      .token_valid   (step_valid),
      .token         (step_token)
   );

   assign out_open   = !rsp_valid_ff || rsp_tready;
   assign advance    = stage_valid_ff && out_open;
   assign req_tready = !stage_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      stage_valid_in = req_accept ? 1'b1 : (stage_valid_ff && !advance);
      state_in   = advance ? step_state   : state_ff;
      brace_in   = advance ? step_brace   : brace_ff;
      bracket_in = advance ? step_bracket : bracket_ff;
      rsp_valid_in = out_open ? (advance && step_valid) : rsp_valid_ff;
      limits_in = limits_ff;
      if (csr_valid) begin
         unique case (csr_index[0])
            REG_KEY_LIMIT:   limits_in.key_limit   = csr_data[KEY_LEN_W-1:0];
            REG_VALUE_LIMIT: limits_in.value_limit = csr_data[VALUE_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff        <= 1'b0;
         state_ff.in_quotes    <= 1'b0;
         state_ff.seeking_key  <= 1'b1;
         state_ff.key_count    <= '0;
         state_ff.value_count  <= '0;
         state_ff.previous_byte <= '0;
         brace_ff              <= '0;
         bracket_ff            <= '0;
         rsp_valid_ff          <= 1'b0;
         limits_ff.key_limit   <= {KEY_LEN_W{1'b1}};
         limits_ff.value_limit <= {VALUE_LEN_W{1'b1}};
      end else begin
         stage_valid_ff <= stage_valid_in;
         state_ff       <= state_in;
         brace_ff       <= brace_in;
         bracket_ff     <= bracket_in;
         rsp_valid_ff   <= rsp_valid_in;
         limits_ff      <= limits_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_byte_ff    <= req_tdata;
         stage_restart_ff <= req_tuser[0];
      end
      if (advance) begin
         rsp_ff <= step_token;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.event_kind;
   assign rsp_tdata  = {7'b0, rsp_ff.value_length, rsp_ff.key_length,
                        rsp_ff.array_depth, rsp_ff.object_depth, rsp_ff.out_char};

   assign rsp_is_commit   = rsp_ff.event_kind == EV_COMMIT;
   assign rsp_report_zero = rsp_ff.key_length == '0 && rsp_ff.value_length == '0 &&
                            rsp_ff.object_depth == '0;
   assign stage_stalled   = stage_valid_ff && rsp_valid_ff && !rsp_tready;

   `include "json_stream_tokenizer_assert.svh"

   `JST_ASSERT_IMPL(a_commit_no_char, clock, reset, rsp_tvalid && rsp_is_commit, rsp_ff.out_char == '0)
   `JST_ASSERT_IMPL(a_char_no_lengths, clock, reset, rsp_tvalid && !rsp_is_commit, rsp_report_zero)
   `JST_ASSERT_NEXT(a_stage_holds, clock, reset, stage_stalled, stage_valid_ff && $stable(state_ff))
   `JST_ASSERT_IMPL(a_no_overrun, clock, reset, req_tvalid && req_tready && stage_valid_ff, advance)

endmodule
